// ----- rtl/hc_pkg.sv -----
package hc_pkg;

    localparam int unsigned RAW_W  = 16;
    localparam int unsigned TF_W   = 32;
    localparam int unsigned HUM_W  = 17;
    localparam int unsigned CIDX_W = 3;
    localparam int unsigned CDAT_W = 16;
    localparam int unsigned NSTG   = 8;

    localparam logic signed [31:0] TEMP_OFS   = 32'sd76800;
    localparam logic signed [31:0] A_ROUND    = 32'sd16384;
    localparam logic signed [31:0] C_OFS      = 32'sd32768;
    localparam logic signed [31:0] D_OFS      = 32'sd2097152;
    localparam logic signed [31:0] E_ROUND    = 32'sd8192;
    localparam logic signed [31:0] HUM_MAX    = 32'sd419430400;

    typedef enum logic [CIDX_W-1:0] {
        REG_H1 = 3'd0,
        REG_H2 = 3'd1,
        REG_H3 = 3'd2,
        REG_H4 = 3'd3,
        REG_H5 = 3'd4,
        REG_H6 = 3'd5
    } cfg_reg_t;

endpackage

// ----- rtl/humidity_compensation.sv -----
// Throughput: one word per cycle while out_stall is low; stages with no valid word fill in under a stall.
// Depth is set by the chain of six dependent 32-bit multiplies, one per stage.
// Reset clears all stage valid bits and the six calibration coefficients.
module humidity_compensation (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [hc_pkg::RAW_W-1:0]          raw_humidity,
    input  logic signed [hc_pkg::TF_W-1:0]    temp_fine,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [hc_pkg::HUM_W-1:0]          humidity_q10,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [hc_pkg::CIDX_W-1:0]         cfg_index,
    input  logic [hc_pkg::CDAT_W-1:0]         cfg_data
);
    import hc_pkg::*;

    logic [7:0]         h1_reg;
    logic signed [15:0] h2_reg;
    logic [7:0]         h3_reg;
    logic signed [15:0] h4_reg;
    logic signed [15:0] h5_reg;
    logic signed [7:0]  h6_reg;

    logic [NSTG:1] vld_reg;
    logic [NSTG:1] rdy;

    // stage payloads
    logic signed [31:0] s1_v_reg;
    logic [RAW_W-1:0]   s1_adc_reg;
    logic signed [31:0] s2_x_reg, s2_m5_reg, s2_b0_reg, s2_c0_reg;
    logic signed [31:0] s3_a_reg, s3_bc_reg;
    logic signed [31:0] s4_a_reg, s4_dh_reg;
    logic signed [31:0] s5_v_reg;
    logic signed [31:0] s6_v_reg, s6_ff_reg;
    logic signed [31:0] s7_v_reg, s7_gh_reg;
    logic [HUM_W-1:0]   s8_hum_reg;

    logic signed [31:0] s1_v_next;
    logic signed [31:0] s2_x_next, s2_m5_next, s2_b0_next, s2_c0_next;
    logic signed [31:0] s3_a_next, s3_b, s3_c, s3_bc_next;
    logic signed [31:0] s4_d, s4_dh_next;
    logic signed [31:0] s5_e, s5_v_next;
    logic signed [31:0] s6_f, s6_ff_next;
    logic signed [31:0] s7_g, s7_gh_next;
    logic signed [31:0] s8_g, s8_v;
    logic [HUM_W-1:0]   s8_hum_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h1_reg <= '0;
            h2_reg <= '0;
            h3_reg <= '0;
            h4_reg <= '0;
            h5_reg <= '0;
            h6_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_H1:  h1_reg <= cfg_data[7:0];
                REG_H2:  h2_reg <= cfg_data;
                REG_H3:  h3_reg <= cfg_data[7:0];
                REG_H4:  h4_reg <= cfg_data;
                REG_H5:  h5_reg <= cfg_data;
                REG_H6:  h6_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // a stage takes a word when it is empty or its word moves on
    always_comb
    begin
        rdy[NSTG] = !vld_reg[NSTG] || !out_stall;
        for (int k = NSTG - 1; k >= 1; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign in_stall     = !rdy[1];
    assign out_valid    = vld_reg[NSTG];
    assign humidity_q10 = s8_hum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (rdy[1])
            begin
                vld_reg[1] <= in_valid;
            end
            for (int k = 2; k <= NSTG; k++)
            begin
                if (rdy[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // datapath, one multiply level per stage in stages 2 to 7
    always_comb
    begin
        s1_v_next  = temp_fine - TEMP_OFS;

        s2_x_next  = $signed({2'b00, s1_adc_reg, 14'd0}) - $signed({h4_reg[11:0], 20'd0});
        s2_m5_next = 32'(32'(h5_reg) * s1_v_reg);
        s2_b0_next = 32'(s1_v_reg * 32'(h6_reg));
        s2_c0_next = 32'(s1_v_reg * $signed({24'd0, h3_reg}));

        s3_a_next  = (s2_x_reg - s2_m5_reg + A_ROUND) >>> 15;
        s3_b       = s2_b0_reg >>> 10;
        s3_c       = (s2_c0_reg >>> 11) + C_OFS;
        s3_bc_next = 32'(s3_b * s3_c);

        s4_d       = (s3_bc_reg >>> 10) + D_OFS;
        s4_dh_next = 32'(s4_d * 32'(h2_reg));

        s5_e       = (s4_dh_reg + E_ROUND) >>> 14;
        s5_v_next  = 32'(s4_a_reg * s5_e);

        s6_f       = s5_v_reg >>> 15;
        s6_ff_next = 32'(s6_f * s6_f);

        s7_g       = s6_ff_reg >>> 7;
        s7_gh_next = 32'(s7_g * $signed({24'd0, h1_reg}));

        s8_g       = s7_gh_reg >>> 4;
        s8_v       = s7_v_reg - s8_g;
        // clamp to zero and to full scale, drop 12 fraction bits
        if (s8_v < 0)
        begin
            s8_hum_next = '0;
        end
        else if (s8_v > HUM_MAX)
        begin
            s8_hum_next = HUM_MAX[12 +: HUM_W];
        end
        else
        begin
            s8_hum_next = s8_v[12 +: HUM_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            s1_v_reg   <= s1_v_next;
            s1_adc_reg <= raw_humidity;
        end
        if (rdy[2])
        begin
            s2_x_reg  <= s2_x_next;
            s2_m5_reg <= s2_m5_next;
            s2_b0_reg <= s2_b0_next;
            s2_c0_reg <= s2_c0_next;
        end
        if (rdy[3])
        begin
            s3_a_reg  <= s3_a_next;
            s3_bc_reg <= s3_bc_next;
        end
        if (rdy[4])
        begin
            s4_a_reg  <= s3_a_reg;
            s4_dh_reg <= s4_dh_next;
        end
        if (rdy[5])
        begin
            s5_v_reg <= s5_v_next;
        end
        if (rdy[6])
        begin
            s6_v_reg  <= s5_v_reg;
            s6_ff_reg <= s6_ff_next;
        end
        if (rdy[7])
        begin
            s7_v_reg  <= s6_v_reg;
            s7_gh_reg <= s7_gh_next;
        end
        if (rdy[8])
        begin
            s8_hum_reg <= s8_hum_next;
        end
    end

endmodule

// ----- rtl/hc_checker.sv -----
module hc_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic [hc_pkg::HUM_W-1:0]  humidity_q10,
    input logic                      cfg_valid,
    input logic                      cfg_ready
);
    import hc_pkg::*;

    localparam logic [HUM_W-1:0] HUM_TOP = HUM_MAX[12 +: HUM_W];

    // hold a stalled result word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(humidity_q10))
        else $error("stalled result word changed or dropped");

    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> humidity_q10 <= HUM_TOP)
        else $error("humidity above full scale");

    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result word present right after reset");

    a_cfg_open: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind humidity_compensation hc_checker u_hc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .humidity_q10 (humidity_q10),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready)
);
